FILE: rtl/core/pdb_pkg.sv
// ----------------------------------------------------------------------------
// pdb_pkg
// Shared types and constants for the positional PID controller with deadband.
// ----------------------------------------------------------------------------
package pdb_pkg;

    typedef enum logic [2:0] {
        CFG_TARGET    = 3'd0,
        CFG_GAIN_P    = 3'd1,
        CFG_GAIN_I    = 3'd2,
        CFG_GAIN_D    = 3'd3,
        CFG_DEAD_BAND = 3'd4
    } cfg_index_t;

    localparam int SampleWidth = 32;
    localparam int GainWidth   = 16;
    localparam int BandWidth   = 24;
    localparam int SumWidth    = 48;
    localparam int CfgWidth    = 32;
    localparam int IndexWidth  = 3;

    localparam logic signed [SampleWidth-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SampleWidth-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [SumWidth-1:0]    S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SumWidth-1:0]    S48_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic signed [SampleWidth-1:0] target;
        logic signed [GainWidth-1:0]   gain_p;
        logic signed [GainWidth-1:0]   gain_i;
        logic signed [GainWidth-1:0]   gain_d;
        logic [BandWidth-1:0]          dead_band;
    } cfg_t;

    typedef struct packed {
        logic signed [SampleWidth-1:0] err;
        logic signed [SampleWidth:0]   diff;
        logic signed [SumWidth-1:0]    sum;
        logic                          clip;
    } integ_word_t;

    typedef struct packed {
        logic signed [47:0] prod_p;
        logic signed [63:0] prod_i;
        logic signed [48:0] prod_d;
        logic               clip;
    } prod_word_t;

endpackage

FILE: rtl/core/pdb_if.sv
// ----------------------------------------------------------------------------
// pdb_if
// Valid/ready channels for measured samples and controller results.
// ----------------------------------------------------------------------------
interface pdb_sample_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  measured;

    modport source (output valid, output measured, input ready);
    modport sink (input valid, input measured, output ready);
endinterface

interface pdb_result_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  drive;
    logic                clipped;

    modport source (output valid, output drive, output clipped, input ready);
    modport sink (input valid, input drive, input clipped, output ready);
endinterface

FILE: rtl/core/pdb_error.sv
// ----------------------------------------------------------------------------
// pdb_error
// Input register, then the saturated error with the deadband applied.
// ----------------------------------------------------------------------------
module pdb_error (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdb_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    measured,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    err
);

    logic                 meas_valid_reg;
    logic signed [31:0]   meas_reg;
    logic                 err_valid_reg;
    logic signed [31:0]   err_reg;
    logic                 err_ready;
    logic signed [32:0]   diff_wide;
    logic signed [31:0]   err_sat;
    logic signed [32:0]   err_ext;
    logic signed [32:0]   band_ext;
    logic signed [31:0]   err_next;

    assign err_ready = !err_valid_reg || out_ready;
    assign in_ready  = !meas_valid_reg || err_ready;

    always_comb
    begin
        diff_wide = {cfg.target[31], cfg.target} - {meas_reg[31], meas_reg};
        if (diff_wide[32] != diff_wide[31])
        begin
            err_sat = diff_wide[32] ? pdb_pkg::S32_MIN : pdb_pkg::S32_MAX;
        end
        else
        begin
            err_sat = diff_wide[31:0];
        end
        err_ext  = {err_sat[31], err_sat};
        band_ext = {9'd0, cfg.dead_band};
        if ((err_ext < band_ext) && (err_ext > -band_ext))
        begin
            err_next = '0;
        end
        else
        begin
            err_next = err_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_valid_reg <= 1'b0;
            err_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                meas_valid_reg <= in_valid;
            end
            if (err_ready)
            begin
                err_valid_reg <= meas_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            meas_reg <= measured;
        end
        if (meas_valid_reg && err_ready)
        begin
            err_reg <= err_next;
        end
    end

    assign out_valid = err_valid_reg;
    assign err       = err_reg;

endmodule

FILE: rtl/core/pdb_integ.sv
// ----------------------------------------------------------------------------
// pdb_integ
// Saturating error integral and error difference; holds the controller state.
// ----------------------------------------------------------------------------
module pdb_integ (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    err,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pdb_pkg::integ_word_t  word
);

    logic                 valid_reg;
    logic signed [47:0]   sum_reg;
    logic signed [47:0]   sum_next;
    logic signed [31:0]   prev_reg;
    logic signed [32:0]   diff_reg;
    logic signed [32:0]   diff_next;
    logic                 clip_reg;
    logic                 clip_next;
    logic signed [48:0]   sum_wide;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sum_wide  = {sum_reg[47], sum_reg} + {{17{err[31]}}, err};
        clip_next = 1'b0;
        if (sum_wide[48] != sum_wide[47])
        begin
            sum_next  = sum_wide[48] ? pdb_pkg::S48_MIN : pdb_pkg::S48_MAX;
            clip_next = 1'b1;
        end
        else
        begin
            sum_next = sum_wide[47:0];
        end
        diff_next = {err[31], err} - {prev_reg[31], prev_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sum_reg   <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (in_valid && in_ready)
            begin
                sum_reg  <= sum_next;
                prev_reg <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            diff_reg <= diff_next;
            clip_reg <= clip_next;
        end
    end

    assign out_valid = valid_reg;
    assign word.err  = prev_reg;
    assign word.diff = diff_reg;
    assign word.sum  = sum_reg;
    assign word.clip = clip_reg;

endmodule

FILE: rtl/core/pdb_mult.sv
// ----------------------------------------------------------------------------
// pdb_mult
// The three gain products, each registered.
// ----------------------------------------------------------------------------
module pdb_mult (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdb_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pdb_pkg::integ_word_t  in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pdb_pkg::prod_word_t   out_word
);

    logic                 valid_reg;
    pdb_pkg::prod_word_t  word_reg;
    pdb_pkg::prod_word_t  word_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        word_next.prod_p = cfg.gain_p * in_word.err;
        word_next.prod_i = cfg.gain_i * in_word.sum;
        word_next.prod_d = cfg.gain_d * in_word.diff;
        word_next.clip   = in_word.clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

FILE: rtl/core/pdb_drive.sv
// ----------------------------------------------------------------------------
// pdb_drive
// Sum of products, scaling to Q16.16, saturation and the result register.
// ----------------------------------------------------------------------------
module pdb_drive (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pdb_pkg::prod_word_t   in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    drive,
    output logic                  clipped
);

    logic                 valid_reg;
    logic signed [31:0]   drive_reg;
    logic signed [31:0]   drive_next;
    logic                 clip_reg;
    logic                 clip_next;
    logic signed [63:0]   acc;
    logic                 fits;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        acc = {{16{in_word.prod_p[47]}}, in_word.prod_p} + in_word.prod_i
              + {{15{in_word.prod_d[48]}}, in_word.prod_d};
        fits = (acc[63:39] == {25{acc[63]}});
        if (fits)
        begin
            drive_next = acc[39:8];
        end
        else
        begin
            drive_next = acc[63] ? pdb_pkg::S32_MIN : pdb_pkg::S32_MAX;
        end
        clip_next = in_word.clip || !fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            drive_reg <= drive_next;
            clip_reg  <= clip_next;
        end
    end

    assign out_valid = valid_reg;
    assign drive     = drive_reg;
    assign clipped   = clip_reg;

endmodule

FILE: rtl/core/positional_pid_with_deadband_core.sv
// ----------------------------------------------------------------------------
// Samples pass the input, error, integral, product and result registers.
// Throughput: one sample word per cycle while result.ready is high, set by
// the five-stage register chain.
// Every stage holds one word and moves on as soon as the next stage frees up.
// Reset clears the configuration, the integral, the previous error and all
// valid flags; there is no clearing pass.
// ----------------------------------------------------------------------------
// positional_pid_with_deadband_core
// Positional PID controller with an error deadband, Q16.16 data, Q8.8 gains.
// ----------------------------------------------------------------------------
module positional_pid_with_deadband_core (
    input  logic                  clk,
    input  logic                  rst_n,
    pdb_sample_if.sink            sample,
    pdb_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    pdb_pkg::cfg_t         cfg_reg;
    logic                  err_valid;
    logic                  err_ready;
    logic signed [31:0]    err;
    logic                  integ_valid;
    logic                  integ_ready;
    pdb_pkg::integ_word_t  integ_word;
    logic                  prod_valid;
    logic                  prod_ready;
    pdb_pkg::prod_word_t   prod_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pdb_pkg::CFG_TARGET:    cfg_reg.target    <= cfg_data;
                pdb_pkg::CFG_GAIN_P:    cfg_reg.gain_p    <= cfg_data[15:0];
                pdb_pkg::CFG_GAIN_I:    cfg_reg.gain_i    <= cfg_data[15:0];
                pdb_pkg::CFG_GAIN_D:    cfg_reg.gain_d    <= cfg_data[15:0];
                pdb_pkg::CFG_DEAD_BAND: cfg_reg.dead_band <= cfg_data[23:0];
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    pdb_error u_error (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .measured  (sample.measured),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .err       (err)
    );

    pdb_integ u_integ (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .err       (err),
        .out_valid (integ_valid),
        .out_ready (integ_ready),
        .word      (integ_word)
    );

    pdb_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (integ_valid),
        .in_ready  (integ_ready),
        .in_word   (integ_word),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_word  (prod_word)
    );

    pdb_drive u_drive (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_word   (prod_word),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .drive     (result.drive),
        .clipped   (result.clipped)
    );

endmodule

FILE: rtl/core/pdb_checker.sv
// ----------------------------------------------------------------------------
// pdb_checker
// Port-level checks of the controller's occupancy, latency and output stall.
// ----------------------------------------------------------------------------
module pdb_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    input  logic         sample_ready,
    input  logic         result_valid,
    input  logic         result_ready,
    input  logic [31:0]  result_drive,
    input  logic         result_clipped
);

    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic        in_acc;
    logic        out_acc;

    assign in_acc  = sample_valid && sample_ready;
    assign out_acc = result_valid && result_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (out_acc && !in_acc)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(result_drive) && $stable(result_clipped)))
        else $error("result word changed while stalled");

    a_max_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= 3'd5) and (result_valid |-> (count_reg != 3'd0)))
        else $error("words in flight out of range");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 3'd0) |-> sample_ready)
        else $error("empty controller refused a sample");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == 3'd0) && in_acc) |-> ##5 result_valid)
        else $error("result missing five cycles after sample");

endmodule

bind positional_pid_with_deadband_core pdb_checker u_pdb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_valid   (sample.valid),
    .sample_ready   (sample.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_drive   (result.drive),
    .result_clipped (result.clipped)
);
